// ----- sv/acss_pkg.sv -----
// Shared types, register codes and constants of the adaptive cruise speed step core.
`default_nettype none
package acss_pkg;

  // Input item: one follower vehicle.
  typedef struct packed {
    logic [15:0]        own_speed;
    logic [19:0]        gap_len;
    logic [15:0]        lead_speed;
    logic [15:0]        lead_max_decel;
    logic [15:0]        lane_limit;
    logic signed [15:0] accel_now;
    logic [15:0]        min_gap;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic [15:0] next_speed;
    logic [1:0]  follow_mode;
  } out_item_t;

  localparam logic [1:0] MODE_HALT    = 2'd0;
  localparam logic [1:0] MODE_BRAKE   = 2'd1;
  localparam logic [1:0] MODE_GAP     = 2'd2;
  localparam logic [1:0] MODE_SPEED   = 2'd3;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_DECEL     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEADWAY_TIME  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COMFORT_ACCEL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COMFORT_DECEL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_GAIN    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RELSPEED_GAIN = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPACING_GAIN  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_SPEED  = 3'd7;

  localparam logic [15:0] RST_MAX_DECEL     = 16'd1152;
  localparam logic [15:0] RST_HEADWAY_TIME  = 16'd256;
  localparam logic [15:0] RST_COMFORT_ACCEL = 16'd384;
  localparam logic [15:0] RST_COMFORT_DECEL = 16'd512;
  localparam logic [15:0] RST_SPEED_GAIN    = 16'd102;
  localparam logic [15:0] RST_RELSPEED_GAIN = 16'd256;
  localparam logic [15:0] RST_SPACING_GAIN  = 16'd26;
  localparam logic [15:0] RST_TARGET_SPEED  = 16'd7680;

  // Step and lag times are Q8.8 in 1..2560, so twelve bits hold them.
  localparam int TIME_W = 12;
  localparam int STEP_TIME_Q8_DEF = 256;
  localparam int LAG_TIME_Q8_DEF = 128;

endpackage
`default_nettype wire

// ----- sv/acss_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with a side tag.
`default_nettype none
module acss_div #(
  parameter int NW = 32,
  parameter int DW = 17,
  parameter int TW = 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_vld,
  input  wire logic [NW-1:0] in_num,
  input  wire logic [DW-1:0] in_den,
  input  wire logic [TW-1:0] in_tag,
  output logic               out_vld,
  output logic [NW-1:0]      out_quo,
  output logic [TW-1:0]      out_tag
);

  // Each stage holds {remainder, dividend bits left / quotient bits so far}.
  logic [DW+NW-1:0] acc_r [1:NW];
  logic [DW-1:0]    den_r [1:NW];
  logic [TW-1:0]    tag_r [1:NW];
  logic             vld_r [1:NW];

  logic [DW+NW-1:0] src_acc [0:NW-1];
  logic [DW-1:0]    src_den [0:NW-1];
  logic [TW-1:0]    src_tag [0:NW-1];
  logic             src_vld [0:NW-1];

  assign src_acc[0] = {{DW{1'b0}}, in_num};
  assign src_den[0] = in_den;
  assign src_tag[0] = in_tag;
  assign src_vld[0] = in_vld;

  for (genvar i = 0; i < NW; i++) begin : g_stage
    logic [DW:0]      hi;
    logic [DW:0]      dif;
    logic             ge;
    logic [DW+NW-1:0] acc_nxt;

    if (i > 0) begin : g_link
      assign src_acc[i] = acc_r[i];
      assign src_den[i] = den_r[i];
      assign src_tag[i] = tag_r[i];
      assign src_vld[i] = vld_r[i];
    end

    assign hi  = src_acc[i][DW+NW-1:NW-1];
    assign ge  = hi >= {1'b0, src_den[i]};
    assign dif = hi - {1'b0, src_den[i]};
    assign acc_nxt = ge ? {dif[DW-1:0], src_acc[i][NW-2:0], 1'b1}
                        : {src_acc[i][DW+NW-2:0], 1'b0};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else begin
        vld_r[i+1] <= src_vld[i];
      end
      acc_r[i+1] <= acc_nxt;
      den_r[i+1] <= src_den[i];
      tag_r[i+1] <= src_tag[i];
    end
  end

  assign out_vld = vld_r[NW];
  assign out_quo = acc_r[NW][NW-1:0];
  assign out_tag = tag_r[NW];

endmodule
`default_nettype wire

// ----- sv/adaptive_cruise_speed_step_core.sv -----
// Top level of the adaptive cruise speed step core: one follower step per item.
`default_nettype none
// The core takes one vehicle item in every clock cycle: busy is always low, and an
// item is accepted at each rising edge where start is high. Its result is driven on
// out_item, marked by out_strobe for one cycle, in the order the items came in. The
// receiver cannot stall the core and none is needed, since results leave at the rate
// items enter. Each item passes through a 32-stage bit-per-stage divider pipeline for
// the safe-gap braking distances (leader and own, side by side), four register stages
// ahead of it (input, products, spacing, gap control), one stage for the safe-gap
// compare after it, two stages of reciprocal multiply for the first-order lag and two
// stages behind that for the clamp and the output.
// Configuration registers are written through cfg_we/cfg_index/cfg_wdata at the rising
// edge where cfg_we is high and must only change while no item is in flight.
module adaptive_cruise_speed_step_core
  import acss_pkg::*;
#(
  parameter int STEP_TIME_Q8 = STEP_TIME_Q8_DEF,
  parameter int LAG_TIME_Q8  = LAG_TIME_Q8_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire in_item_t              in_item,
  output logic                       out_strobe,
  output out_item_t                  out_item,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam logic [TIME_W-1:0] STEP   = TIME_W'(STEP_TIME_Q8);
  localparam logic signed [TIME_W:0] STEP_S = (TIME_W+1)'(STEP_TIME_Q8);
  localparam logic [30:0] LAG_M1 = 31'(LAG_TIME_Q8 - 1);

  // Division by the lag time as a reciprocal multiply: for every numerator below
  // 2^31, floor(n * LAG_RCP / 2^LAG_SH) equals floor(n / LAG_TIME_Q8).
  localparam int     LAG_SH    = 31 + $clog2(LAG_TIME_Q8);
  localparam longint LAG_RCP_L = ((longint'(1) << LAG_SH) + longint'(LAG_TIME_Q8) - 64'sd1)
                                 / longint'(LAG_TIME_Q8);
  localparam logic [31:0] LAG_RCP = 32'(LAG_RCP_L);

  // Tags that ride along with the dividers.
  typedef struct packed {
    logic [20:0] gap_total;
    logic [19:0] own_step;
    logic [15:0] own;
  } tag_a_t;

  typedef struct packed {
    logic signed [20:0] brake_v;
    logic signed [15:0] acc;
    logic signed [31:0] x;
    logic               g_lt_v;
  } tag_b_t;

  typedef struct packed {
    logic               brake;
    logic signed [20:0] brake_v;
    logic [15:0]        own;
    logic signed [15:0] acc;
    logic               g_lt_v;
    logic               neg;
  } tag_l_t;

  // ---------------------------------------------------------------------------
  // Configuration registers.
  logic [15:0] max_decel_r, headway_time_r, comfort_accel_r, comfort_decel_r;
  logic [15:0] speed_gain_r, relspeed_gain_r, spacing_gain_r, target_speed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_decel_r     <= RST_MAX_DECEL;
      headway_time_r  <= RST_HEADWAY_TIME;
      comfort_accel_r <= RST_COMFORT_ACCEL;
      comfort_decel_r <= RST_COMFORT_DECEL;
      speed_gain_r    <= RST_SPEED_GAIN;
      relspeed_gain_r <= RST_RELSPEED_GAIN;
      spacing_gain_r  <= RST_SPACING_GAIN;
      target_speed_r  <= RST_TARGET_SPEED;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAX_DECEL:     max_decel_r     <= cfg_wdata;
        REG_HEADWAY_TIME:  headway_time_r  <= cfg_wdata;
        REG_COMFORT_ACCEL: comfort_accel_r <= cfg_wdata;
        REG_COMFORT_DECEL: comfort_decel_r <= cfg_wdata;
        REG_SPEED_GAIN:    speed_gain_r    <= cfg_wdata;
        REG_RELSPEED_GAIN: relspeed_gain_r <= cfg_wdata;
        REG_SPACING_GAIN:  spacing_gain_r  <= cfg_wdata;
        REG_TARGET_SPEED:  target_speed_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The pipeline never stalls, so an item is taken whenever start is high.
  assign busy = 1'b0;

  // ---------------------------------------------------------------------------
  // Stage A: input register.
  logic     a_vld_r;
  in_item_t a_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= start & ~busy;
    end
    a_item_r <= in_item;
  end

  // ---------------------------------------------------------------------------
  // Stage B: the first round of products.
  logic [15:0]        b_vint;
  logic signed [16:0] b_dv, b_dl_spd, b_sg, b_rg;
  logic [15:0]        b_ldec, b_mdec;

  logic               b_vld_r;
  logic [31:0]        b_lead2_r, b_own2_r, b_ownhw_r;
  logic [16:0]        b_dl_r, b_dm_r;
  logic [27:0]        b_ownstep_r, b_mdstep_r;
  logic signed [33:0] b_svp_r, b_rvp_r;
  logic [19:0]        b_gap_r;
  logic [20:0]        b_gap_total_r;
  logic [15:0]        b_own_r;
  logic signed [15:0] b_acc_r;

  always_comb begin
    b_vint = (target_speed_r < a_item_r.lane_limit) ? target_speed_r : a_item_r.lane_limit;
    b_dv     = $signed({1'b0, b_vint}) - $signed({1'b0, a_item_r.own_speed});
    b_dl_spd = $signed({1'b0, a_item_r.lead_speed}) - $signed({1'b0, a_item_r.own_speed});
    b_sg     = $signed({1'b0, speed_gain_r});
    b_rg     = $signed({1'b0, relspeed_gain_r});
    // A zero deceleration counts as one in the braking distances.
    b_ldec = (a_item_r.lead_max_decel == 16'd0) ? 16'd1 : a_item_r.lead_max_decel;
    b_mdec = (max_decel_r == 16'd0) ? 16'd1 : max_decel_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else begin
      b_vld_r <= a_vld_r;
    end
    b_lead2_r     <= 32'(a_item_r.lead_speed) * 32'(a_item_r.lead_speed);
    b_own2_r      <= 32'(a_item_r.own_speed) * 32'(a_item_r.own_speed);
    b_ownhw_r     <= 32'(a_item_r.own_speed) * 32'(headway_time_r);
    b_dl_r        <= {b_ldec, 1'b0};
    b_dm_r        <= {b_mdec, 1'b0};
    b_ownstep_r   <= 28'(a_item_r.own_speed) * 28'(STEP);
    b_mdstep_r    <= 28'(max_decel_r) * 28'(STEP);
    b_svp_r       <= 34'(b_sg) * 34'(b_dv);
    b_rvp_r       <= 34'(b_rg) * 34'(b_dl_spd);
    b_gap_r       <= a_item_r.gap_len;
    b_gap_total_r <= 21'(a_item_r.gap_len) + 21'(a_item_r.min_gap);
    b_own_r       <= a_item_r.own_speed;
    b_acc_r       <= a_item_r.accel_now;
  end

  // ---------------------------------------------------------------------------
  // Stage C: spacing error and its gain product; brake speed.
  logic signed [25:0] c_spacing;
  logic signed [16:0] c_pg;

  logic               c_vld_r;
  logic signed [25:0] c_av_r, c_ar_r;
  logic signed [42:0] c_spp_r;
  logic [31:0]        c_lead2_r, c_own2_r;
  logic [16:0]        c_dl_r, c_dm_r;
  logic [19:0]        c_ownstep_r;
  logic signed [20:0] c_brake_v_r;
  logic [20:0]        c_gap_total_r;
  logic [15:0]        c_own_r;
  logic signed [15:0] c_acc_r;

  always_comb begin
    c_spacing = $signed({6'b0, b_gap_r}) - $signed({2'b0, b_ownhw_r[31:8]});
    c_pg      = $signed({1'b0, spacing_gain_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else begin
      c_vld_r <= b_vld_r;
    end
    // Arithmetic shift by eight is the floor of the Q8.8 product.
    c_av_r        <= b_svp_r[33:8];
    c_ar_r        <= b_rvp_r[33:8];
    c_spp_r       <= 43'(c_pg) * 43'(c_spacing);
    c_lead2_r     <= b_lead2_r;
    c_own2_r      <= b_own2_r;
    c_dl_r        <= b_dl_r;
    c_dm_r        <= b_dm_r;
    c_ownstep_r   <= b_ownstep_r[27:8];
    c_brake_v_r   <= $signed({5'b0, b_own_r}) - $signed({1'b0, b_mdstep_r[27:8]});
    c_gap_total_r <= b_gap_total_r;
    c_own_r       <= b_own_r;
    c_acc_r       <= b_acc_r;
  end

  // ---------------------------------------------------------------------------
  // Stage D: gap-control acceleration, the lesser command, and its error to the
  // current acceleration. The error is limited to +/-2^30: past that the lag
  // output is far outside any comfort bound, so the final clamp is unchanged.
  localparam logic signed [36:0] X_LIM = 37'sd1073741824;

  logic signed [35:0] d_ag, d_av, d_ctl;
  logic signed [36:0] d_x;
  logic signed [31:0] d_xc;

  logic               d_vld_r;
  logic [31:0]        d_lead2_r, d_own2_r;
  logic [16:0]        d_dl_r, d_dm_r;
  tag_a_t             d_tag_a_r;
  tag_b_t             d_tag_b_r;

  always_comb begin
    d_ag  = 36'(c_ar_r) + 36'($signed(c_spp_r[42:8]));
    d_av  = 36'(c_av_r);
    d_ctl = (d_ag < d_av) ? d_ag : d_av;
    d_x   = 37'(d_ctl) - 37'(c_acc_r);
    if (d_x > X_LIM) begin
      d_xc = 32'(X_LIM);
    end else if (d_x < -X_LIM) begin
      d_xc = 32'(-X_LIM);
    end else begin
      d_xc = 32'(d_x);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
    end else begin
      d_vld_r <= c_vld_r;
    end
    d_lead2_r           <= c_lead2_r;
    d_own2_r            <= c_own2_r;
    d_dl_r              <= c_dl_r;
    d_dm_r              <= c_dm_r;
    d_tag_a_r.gap_total <= c_gap_total_r;
    d_tag_a_r.own_step  <= c_ownstep_r;
    d_tag_a_r.own       <= c_own_r;
    d_tag_b_r.brake_v   <= c_brake_v_r;
    d_tag_b_r.acc       <= c_acc_r;
    d_tag_b_r.x         <= d_xc;
    d_tag_b_r.g_lt_v    <= (d_ag < d_av);
  end

  // ---------------------------------------------------------------------------
  // Braking distances: leader speed^2 / (2 * leader decel) and the same for the
  // follower with its own emergency deceleration.
  logic        dl_vld, dm_vld;
  logic [31:0] dl_quo, dm_quo;
  tag_a_t      dl_tag;
  tag_b_t      dm_tag;

  acss_div #(.NW(32), .DW(17), .TW($bits(tag_a_t))) u_div_lead (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (d_vld_r),
    .in_num  (d_lead2_r),
    .in_den  (d_dl_r),
    .in_tag  (d_tag_a_r),
    .out_vld (dl_vld),
    .out_quo (dl_quo),
    .out_tag (dl_tag)
  );

  acss_div #(.NW(32), .DW(17), .TW($bits(tag_b_t))) u_div_own (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (d_vld_r),
    .in_num  (d_own2_r),
    .in_den  (d_dm_r),
    .in_tag  (d_tag_b_r),
    .out_vld (dm_vld),
    .out_quo (dm_quo),
    .out_tag (dm_tag)
  );

  // ---------------------------------------------------------------------------
  // Stage E: safe gap compare and the lag numerator (error times step time).
  logic signed [34:0] e_gsafe;

  logic               e_vld_r;
  logic               e_brake_r;
  logic signed [44:0] e_p_r;
  logic signed [20:0] e_brake_v_r;
  logic [15:0]        e_own_r;
  logic signed [15:0] e_acc_r;
  logic               e_g_lt_v_r;

  always_comb begin
    e_gsafe = 35'(dl_tag.own_step) - 35'(dl_quo) + 35'(dm_quo) + 35'sd512;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_vld_r <= 1'b0;
    end else begin
      e_vld_r <= dl_vld & dm_vld;
    end
    e_brake_r   <= $signed({14'b0, dl_tag.gap_total}) <= e_gsafe;
    e_p_r       <= 45'(dm_tag.x) * 45'(STEP_S);
    e_brake_v_r <= dm_tag.brake_v;
    e_own_r     <= dl_tag.own;
    e_acc_r     <= dm_tag.acc;
    e_g_lt_v_r  <= dm_tag.g_lt_v;
  end

  // ---------------------------------------------------------------------------
  // Lag division: floor(p / LAG) on magnitudes. A negative numerator is divided
  // as |p| + LAG - 1 and negated afterwards, which gives the floor.
  localparam logic signed [44:0] P_LIM = 45'sd1073741824;

  logic signed [44:0] f_pc;
  logic [30:0]        f_mag, f_num;
  tag_l_t             f_tag;

  always_comb begin
    if (e_p_r > P_LIM) begin
      f_pc = P_LIM;
    end else if (e_p_r < -P_LIM) begin
      f_pc = -P_LIM;
    end else begin
      f_pc = e_p_r;
    end
    f_mag = f_pc[44] ? 31'(-f_pc) : 31'(f_pc);
    f_num = f_pc[44] ? f_mag + LAG_M1 : f_mag;
    f_tag.brake   = e_brake_r;
    f_tag.brake_v = e_brake_v_r;
    f_tag.own     = e_own_r;
    f_tag.acc     = e_acc_r;
    f_tag.g_lt_v  = e_g_lt_v_r;
    f_tag.neg     = f_pc[44];
  end

  // Stage F1: the numerator times the low and high halves of the reciprocal.
  logic        f1_vld_r;
  logic [46:0] f1_lo_r, f1_hi_r;
  tag_l_t      f1_tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_vld_r <= 1'b0;
    end else begin
      f1_vld_r <= e_vld_r;
    end
    f1_lo_r  <= 47'(f_num) * 47'(LAG_RCP[15:0]);
    f1_hi_r  <= 47'(f_num) * 47'(LAG_RCP[31:16]);
    f1_tag_r <= f_tag;
  end

  // Stage F2: combine the halves and keep the quotient bits.
  logic [62:0] f2_sum;

  logic        lg_vld_r;
  logic [30:0] lg_quo_r;
  tag_l_t      lg_tag_r;

  always_comb begin
    f2_sum = 63'(f1_lo_r) + {f1_hi_r, 16'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lg_vld_r <= 1'b0;
    end else begin
      lg_vld_r <= f1_vld_r;
    end
    lg_quo_r <= 31'(f2_sum >> LAG_SH);
    lg_tag_r <= f1_tag_r;
  end

  // ---------------------------------------------------------------------------
  // Stage G: add the current acceleration back and clamp to comfort limits.
  logic signed [32:0] g_q, g_des, g_a;

  logic               g_vld_r;
  logic signed [17:0] g_a_r;
  logic               g_brake_r;
  logic signed [20:0] g_brake_v_r;
  logic [15:0]        g_own_r;
  logic               g_g_lt_v_r;

  always_comb begin
    g_q   = lg_tag_r.neg ? -33'(lg_quo_r) : 33'(lg_quo_r);
    g_des = g_q + 33'(lg_tag_r.acc);
    if (g_des > $signed({17'b0, comfort_accel_r})) begin
      g_a = $signed({17'b0, comfort_accel_r});
    end else if (g_des < -$signed({17'b0, comfort_decel_r})) begin
      g_a = -$signed({17'b0, comfort_decel_r});
    end else begin
      g_a = g_des;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_vld_r <= 1'b0;
    end else begin
      g_vld_r <= lg_vld_r;
    end
    g_a_r       <= 18'(g_a);
    g_brake_r   <= lg_tag_r.brake;
    g_brake_v_r <= lg_tag_r.brake_v;
    g_own_r     <= lg_tag_r.own;
    g_g_lt_v_r  <= lg_tag_r.g_lt_v;
  end

  // ---------------------------------------------------------------------------
  // Stage H: apply the acceleration for one step, saturate, pick the mode.
  logic signed [30:0] h_dv;
  logic signed [23:0] h_v;
  out_item_t          h_item;

  always_comb begin
    h_dv = 31'(g_a_r) * 31'(STEP_S);
    h_v  = 24'($signed({1'b0, g_own_r})) + 24'($signed(h_dv[30:8]));
    if (g_brake_r) begin
      if (g_brake_v_r <= 21'sd0) begin
        h_item.next_speed  = 16'd0;
        h_item.follow_mode = MODE_HALT;
      end else begin
        h_item.next_speed  = g_brake_v_r[15:0];
        h_item.follow_mode = MODE_BRAKE;
      end
    end else begin
      if (h_v <= 24'sd0) begin
        h_item.next_speed = 16'd0;
      end else if (h_v > 24'sd65535) begin
        h_item.next_speed = 16'hFFFF;
      end else begin
        h_item.next_speed = h_v[15:0];
      end
      if (h_v <= 24'sd0) begin
        h_item.follow_mode = MODE_HALT;
      end else if (g_g_lt_v_r) begin
        h_item.follow_mode = MODE_GAP;
      end else begin
        h_item.follow_mode = MODE_SPEED;
      end
    end
  end

  logic      out_strobe_r;
  out_item_t out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= g_vld_r;
    end
    out_item_r <= h_item;
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule
`default_nettype wire
